// File: rtl/twr_pkg.sv
package twr_pkg;

  localparam int STAMP_BITS_DEF    = 40;
  localparam int TOF_FRAC_BITS_DEF = 8;

  localparam int SPAN_W   = 32;
  localparam int PROD_W   = 2 * SPAN_W;
  localparam int DEN_W    = SPAN_W + 2;
  localparam int TOF_W    = 40;
  localparam int TIME_W   = 40;
  localparam int ADDR_W   = 64;
  localparam int SEQ_W    = 8;
  localparam int DELAY_W  = 16;
  localparam int TDATA_W  = 304;

  localparam logic [ADDR_W-1:0]  NODE_ADDR_RST = 64'hbccf_0000_0000_0000;
  localparam logic [DELAY_W-1:0] TX_DELAY_RST  = 16'd16475;
  localparam logic [DELAY_W-1:0] RX_DELAY_RST  = 16'd16476;

  localparam logic [1:0] REG_NODE_ADDR = 2'd0;
  localparam logic [1:0] REG_TX_DELAY  = 2'd1;
  localparam logic [1:0] REG_RX_DELAY  = 2'd2;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_TX    = 2'd1;
  localparam logic [1:0] ACT_RX    = 2'd2;

  localparam logic [2:0] FRM_POLL   = 3'd0;
  localparam logic [2:0] FRM_ANSWER = 3'd1;
  localparam logic [2:0] FRM_FINAL  = 3'd2;
  localparam logic [2:0] FRM_REPORT = 3'd3;

  typedef enum logic [1:0] {
    ST_POLL   = 2'd0,
    ST_ANSWER = 2'd1,
    ST_FINAL  = 2'd2,
    ST_REPORT = 2'd3
  } send_type_t;

  typedef struct packed {
    logic [3:0]        pad;
    logic [TIME_W-1:0] rep_final_rx;
    logic [TIME_W-1:0] rep_answer_tx;
    logic [TIME_W-1:0] rep_poll_rx;
    logic              frame_empty;
    logic [TIME_W-1:0] event_time;
    logic [ADDR_W-1:0] frame_dest;
    logic [ADDR_W-1:0] frame_source;
    logic [SEQ_W-1:0]  frame_seq;
    logic [2:0]        frame_type;
  } in_data_t;

  typedef struct packed {
    logic [5:0]        pad;
    logic [TOF_W-1:0]  tof_ticks;
    logic [TIME_W-1:0] out_final_rx;
    logic [TIME_W-1:0] out_answer_tx;
    logic [TIME_W-1:0] out_poll_rx;
    logic [ADDR_W-1:0] send_dest;
    logic [ADDR_W-1:0] send_source;
    logic [SEQ_W-1:0]  send_seq;
    logic [1:0]        send_type;
  } out_data_t;

  typedef struct packed {
    logic             done;
    logic [TOF_W-1:0] tof;
  } div_res_t;

endpackage

// File: rtl/uwb_two_way_ranging_engine_top.sv
// Start, transmit-done, non-report and non-matching report frames go straight into the
// output register. A matching report passes through the two bit-serial multipliers,
// run in parallel, a subtract step and the bit-serial divider, plus control.
// A new request is taken only in idle, with no ranging in progress, and once the output
// register is empty or being read in that cycle.
// Reset (rst_n low, synchronous): stamps, sequence, peer cleared, last sent type poll,
// registers back to their defaults.
module uwb_two_way_ranging_engine_top #(
  parameter int STAMP_BITS    = twr_pkg::STAMP_BITS_DEF,
  parameter int TOF_FRAC_BITS = twr_pkg::TOF_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // frame_type, frame_seq, frame_source, frame_dest, event_time, frame_empty,
  // rep_poll_rx, rep_answer_tx, rep_final_rx, zero pad
  input  logic [twr_pkg::TDATA_W-1:0] in_tdata,
  // action
  input  logic [1:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // send_type, send_seq, send_source, send_dest, out_poll_rx, out_answer_tx,
  // out_final_rx, tof_ticks, zero pad
  output logic [twr_pkg::TDATA_W-1:0] out_tdata,
  // send_now, range_valid
  output logic [1:0]                  out_tuser,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [twr_pkg::ADDR_W-1:0]  cfg_data
);
  import twr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SUB  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r;

  logic [ADDR_W-1:0]  node_addr_r;
  logic [DELAY_W-1:0] tx_delay_r;
  logic [DELAY_W-1:0] rx_delay_r;

  logic [STAMP_BITS-1:0] poll_tx_r, poll_rx_r, answer_tx_r, answer_rx_r, final_tx_r, final_rx_r;
  logic [SEQ_W-1:0]      cur_seq_r;
  logic [ADDR_W-1:0]     peer_r;
  send_type_t            last_r;

  logic       out_valid_r;
  out_data_t  out_data_r;
  logic [1:0] out_user_r;

  logic              mul_start_r;
  logic              div_start_r;
  logic [DEN_W-1:0]  den_r;
  logic [PROD_W-1:0] mag_r;
  logic              neg_r;
  logic              rv_r;
  logic [TOF_W-1:0]  tof_r;

  in_data_t        in_d;
  logic            in_acc;
  logic            rx_ok;
  logic            run_tof;
  logic            seq_hit;
  logic            peer_hit;
  logic [STAMP_BITS-1:0] tx_stamp;
  logic [STAMP_BITS-1:0] rx_stamp;
  out_data_t       resp;
  logic [1:0]      resp_user;

  logic [SPAN_W-1:0] tround1, treply1, tround2, treply2;
  logic [DEN_W-1:0]  den_sum;
  logic              mul1_done, mul2_done;
  logic [PROD_W-1:0] p1, p2;
  div_res_t          div_res;

  assign in_d      = in_data_t'(in_tdata);
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  assign tx_stamp = STAMP_BITS'(in_d.event_time) + STAMP_BITS'(tx_delay_r);
  assign rx_stamp = STAMP_BITS'(in_d.event_time) - STAMP_BITS'(rx_delay_r);
  assign rx_ok    = (in_tuser == ACT_RX) && !in_d.frame_empty;
  assign seq_hit  = in_d.frame_seq == cur_seq_r;
  assign peer_hit = in_d.frame_source == peer_r;
  assign run_tof  = rx_ok && (in_d.frame_type == FRM_REPORT) && seq_hit;

  always_comb begin
    resp      = '0;
    resp_user = '0;
    if (in_tuser == ACT_START) begin
      resp_user[0]     = 1'b1;
      resp.send_type   = ST_POLL;
      resp.send_seq    = SEQ_W'(1);
      resp.send_source = node_addr_r;
      resp.send_dest   = node_addr_r;
    end else if (rx_ok) begin
      resp.send_seq    = in_d.frame_seq;
      resp.send_source = in_d.frame_dest;
      resp.send_dest   = in_d.frame_source;
      case (in_d.frame_type)
        FRM_POLL: begin
          resp_user[0]   = 1'b1;
          resp.send_type = ST_ANSWER;
        end
        FRM_ANSWER: begin
          resp_user[0]   = seq_hit;
          resp.send_type = ST_FINAL;
        end
        FRM_FINAL: begin
          resp_user[0]       = peer_hit;
          resp.send_type     = ST_REPORT;
          resp.out_poll_rx   = TIME_W'(poll_rx_r);
          resp.out_answer_tx = TIME_W'(answer_tx_r);
          resp.out_final_rx  = TIME_W'(rx_stamp);
        end
        default: resp_user[0] = 1'b0;
      endcase
      if (!resp_user[0]) resp = '0;
    end
  end

  assign tround1 = answer_rx_r[SPAN_W-1:0] - poll_tx_r[SPAN_W-1:0];
  assign treply1 = answer_tx_r[SPAN_W-1:0] - poll_rx_r[SPAN_W-1:0];
  assign tround2 = final_rx_r[SPAN_W-1:0]  - answer_tx_r[SPAN_W-1:0];
  assign treply2 = final_tx_r[SPAN_W-1:0]  - answer_rx_r[SPAN_W-1:0];
  assign den_sum = DEN_W'(tround1) + DEN_W'(tround2) + DEN_W'(treply1) + DEN_W'(treply2);

  twr_mul u_mul_round (
    .clk(clk), .rst_n(rst_n), .start(mul_start_r),
    .a(tround1), .b(tround2), .done(mul1_done), .p(p1)
  );

  twr_mul u_mul_reply (
    .clk(clk), .rst_n(rst_n), .start(mul_start_r),
    .a(treply1), .b(treply2), .done(mul2_done), .p(p2)
  );

  twr_div #(.FRAC(TOF_FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r),
    .mag(mag_r), .den(den_r), .neg(neg_r), .res(div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      node_addr_r <= NODE_ADDR_RST;
      tx_delay_r  <= TX_DELAY_RST;
      rx_delay_r  <= RX_DELAY_RST;
      poll_tx_r   <= '0;
      poll_rx_r   <= '0;
      answer_tx_r <= '0;
      answer_rx_r <= '0;
      final_tx_r  <= '0;
      final_rx_r  <= '0;
      cur_seq_r   <= '0;
      peer_r      <= '0;
      last_r      <= ST_POLL;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_NODE_ADDR: node_addr_r <= cfg_data;
          REG_TX_DELAY:  tx_delay_r  <= cfg_data[DELAY_W-1:0];
          REG_RX_DELAY:  rx_delay_r  <= cfg_data[DELAY_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tuser == ACT_START) begin
              poll_tx_r   <= '0;
              poll_rx_r   <= '0;
              answer_tx_r <= '0;
              answer_rx_r <= '0;
              final_tx_r  <= '0;
              final_rx_r  <= '0;
              peer_r      <= '0;
              cur_seq_r   <= SEQ_W'(1);
              last_r      <= ST_POLL;
            end else if (in_tuser == ACT_TX) begin
              case (last_r)
                ST_POLL:   poll_tx_r   <= tx_stamp;
                ST_ANSWER: answer_tx_r <= tx_stamp;
                ST_FINAL:  final_tx_r  <= tx_stamp;
                default: ;
              endcase
            end else if (rx_ok) begin
              case (in_d.frame_type)
                FRM_POLL: begin
                  peer_r    <= in_d.frame_source;
                  poll_rx_r <= rx_stamp;
                  last_r    <= ST_ANSWER;
                end
                FRM_ANSWER: if (seq_hit) begin
                  answer_rx_r <= rx_stamp;
                  last_r      <= ST_FINAL;
                end
                FRM_FINAL: if (peer_hit) begin
                  final_rx_r <= rx_stamp;
                  last_r     <= ST_REPORT;
                end
                FRM_REPORT: if (seq_hit) begin
                  poll_rx_r   <= STAMP_BITS'(in_d.rep_poll_rx);
                  answer_tx_r <= STAMP_BITS'(in_d.rep_answer_tx);
                  final_rx_r  <= STAMP_BITS'(in_d.rep_final_rx);
                end
                default: ;
              endcase
            end
            if (run_tof) begin
              mul_start_r <= 1'b1;
              state_r     <= S_MUL;
            end else begin
              out_data_r  <= resp;
              out_user_r  <= resp_user;
              out_valid_r <= 1'b1;
            end
          end
        end
        S_MUL: begin
          if (mul_start_r) den_r <= den_sum;
          if (mul1_done) state_r <= S_SUB;
        end
        S_SUB: begin
          if (den_r == '0) begin
            rv_r    <= 1'b0;
            tof_r   <= '0;
            state_r <= S_DONE;
          end else begin
            neg_r       <= p2 > p1;
            mag_r       <= (p2 > p1) ? p2 - p1 : p1 - p2;
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            rv_r    <= 1'b1;
            tof_r   <= div_res.tof;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r           <= '0;
            out_data_r.tof_ticks <= tof_r;
            out_user_r           <= {rv_r, 1'b0};
            out_valid_r          <= 1'b1;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_data_r);
  assign out_tuser  = out_user_r;

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == S_DIV)
    else $error("divider finished outside its state");

  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    mul1_done == mul2_done)
    else $error("multipliers out of step");

  a_range_no_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r[1] |-> !out_user_r[0])
    else $error("range result also requests a send");

  a_report_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && run_tof |=> state_r == S_MUL && mul_start_r)
    else $error("report did not start the multipliers");

endmodule

// File: rtl/twr_mul.sv
module twr_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [twr_pkg::SPAN_W-1:0] a,
  input  logic [twr_pkg::SPAN_W-1:0] b,
  output logic                       done,
  output logic [twr_pkg::PROD_W-1:0] p
);
  import twr_pkg::*;

  localparam int CW = $clog2(SPAN_W);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [PROD_W-1:0] mcand_r;
  logic [SPAN_W-1:0] mplr_r;
  logic [PROD_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(SPAN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift-add, one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= PROD_W'(a);
      mplr_r  <= b;
      acc_r   <= '0;
    end else if (busy_r) begin
      if (mplr_r[0]) acc_r <= acc_r + mcand_r;
      mcand_r <= mcand_r << 1;
      mplr_r  <= mplr_r >> 1;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// File: rtl/twr_div.sv
module twr_div #(
  parameter int FRAC = twr_pkg::TOF_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [twr_pkg::PROD_W-1:0] mag,
  input  logic [twr_pkg::DEN_W-1:0]  den,
  input  logic                       neg,
  output twr_pkg::div_res_t          res
);
  import twr_pkg::*;

  localparam int N  = PROD_W + FRAC;
  localparam int CW = $clog2(N);
  localparam int QW = TOF_W + 1;
  localparam logic [QW:0] NEG_LIM = (QW + 1)'(1) << (TOF_W - 1);
  localparam logic [QW:0] POS_LIM = NEG_LIM - 1'b1;

  logic             busy_r;
  logic             fin_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [N-1:0]     dvd_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [QW-1:0]    q_r;
  logic             ovf_r;
  logic             neg_r;
  logic [TOF_W-1:0] tof_r;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;
  logic           round_up;
  logic [QW:0]    qq;
  logic [QW:0]    mag_s;

  assign trial    = {rem_r, dvd_r[N-1]};
  assign ge       = trial >= {1'b0, den_r};
  assign diff     = trial - {1'b0, den_r};
  assign round_up = {rem_r, 1'b0} >= {1'b0, den_r};
  assign qq       = {1'b0, q_r} + (QW + 1)'(round_up);

  always_comb begin
    if (neg_r) mag_s = (ovf_r || qq > NEG_LIM) ? NEG_LIM : qq;
    else       mag_s = (ovf_r || qq > POS_LIM) ? POS_LIM : qq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(N - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        done_r <= 1'b1;
      end
    end
  end

  // restoring division, one quotient bit a cycle; high bits fold into a sticky flag
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= N'(mag) << FRAC;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      den_r <= den;
      neg_r <= neg;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_r   <= {q_r[QW-2:0], ge};
      ovf_r <= ovf_r | q_r[QW-1];
    end else if (fin_r) begin
      tof_r <= neg_r ? TOF_W'((QW + 1)'(0) - mag_s) : TOF_W'(mag_s);
    end
  end

  assign res.done = done_r;
  assign res.tof  = tof_r;

endmodule

// File: bench/uwb_two_way_ranging_engine_top_tb.sv
module uwb_two_way_ranging_engine_top_tb;
  import twr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;

  typedef struct packed {
    logic       send_now;
    logic       range_valid;
    out_data_t  data;
  } frame_out_t;

  always #5 clk = ~clk;

  uwb_two_way_ranging_engine_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [ADDR_W-1:0] own_addr;
  logic [15:0] tx_add, rx_sub;
  logic [TIME_W-1:0] t_poll_tx, t_poll_rx, t_ans_tx, t_ans_rx, t_fin_tx, t_fin_rx;
  logic [7:0] sess_seq;
  logic [ADDR_W-1:0] sess_peer;
  send_type_t last_type;

  frame_out_t expected_frames[$];
  int errors = 0;
  bit rx_noidle = 1'b0;
  bit tx_noidle = 1'b0;

  task automatic report(input string what);
    $display("MISMATCH %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [31:0] span(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    return a[31:0] - b[31:0];
  endfunction

  function automatic logic [TOF_W:0] flight_time();
    logic [63:0] r1, p1, r2, p2, m1, m2, den, mag, q, r;
    logic neg;
    r1 = span(t_ans_rx, t_poll_tx);
    p1 = span(t_ans_tx, t_poll_rx);
    r2 = span(t_fin_rx, t_ans_tx);
    p2 = span(t_fin_tx, t_ans_rx);
    m1 = r1 * r2;
    m2 = p1 * p2;
    den = r1 + r2 + p1 + p2;
    if (den == 0) return '0;
    neg = m2 > m1;
    mag = neg ? m2 - m1 : m1 - m2;
    q = mag / den;
    r = mag % den;
    for (int i = 0; i < 8; i++) begin
      if (q > 64'h80_0000_0000) q = 64'h80_0000_0001;
      q = q << 1;
      r = r << 1;
      if (r >= den) begin
        r -= den;
        q[0] = 1'b1;
      end
    end
    if (r >= den - r) q += 64'd1;
    if (neg) begin
      if (q > 64'h80_0000_0000) q = 64'h80_0000_0000;
      q = 64'd0 - q;
    end else if (q > 64'h7F_FFFF_FFFF) q = 64'h7F_FFFF_FFFF;
    return {1'b1, q[TOF_W-1:0]};
  endfunction

  function automatic frame_out_t predict(input logic [1:0] act, input in_data_t d);
    frame_out_t o;
    logic [TIME_W-1:0] st;
    logic [TOF_W:0] tf;
    o = '0;
    case (act)
      ACT_START: begin
        {t_poll_tx, t_poll_rx, t_ans_tx, t_ans_rx, t_fin_tx, t_fin_rx} = '0;
        sess_peer = '0;
        sess_seq = 8'd1;
        o.send_now = 1'b1;
        o.data.send_type = ST_POLL;
        o.data.send_seq = 8'd1;
        o.data.send_source = own_addr;
        o.data.send_dest = own_addr;
        last_type = ST_POLL;
      end
      ACT_TX: begin
        st = d.event_time + TIME_W'(tx_add);
        case (last_type)
          ST_POLL: t_poll_tx = st;
          ST_ANSWER: t_ans_tx = st;
          ST_FINAL: t_fin_tx = st;
          default: ;
        endcase
      end
      ACT_RX: if (!d.frame_empty) begin
        st = d.event_time - TIME_W'(rx_sub);
        o.data.send_seq = d.frame_seq;
        o.data.send_source = d.frame_dest;
        o.data.send_dest = d.frame_source;
        case (d.frame_type)
          FRM_POLL: begin
            sess_peer = d.frame_source;
            t_poll_rx = st;
            o.send_now = 1'b1;
            o.data.send_type = ST_ANSWER;
            last_type = ST_ANSWER;
          end
          FRM_ANSWER: if (d.frame_seq == sess_seq) begin
            t_ans_rx = st;
            o.send_now = 1'b1;
            o.data.send_type = ST_FINAL;
            last_type = ST_FINAL;
          end
          FRM_FINAL: if (d.frame_source == sess_peer) begin
            t_fin_rx = st;
            o.send_now = 1'b1;
            o.data.send_type = ST_REPORT;
            last_type = ST_REPORT;
            o.data.out_poll_rx = t_poll_rx;
            o.data.out_answer_tx = t_ans_tx;
            o.data.out_final_rx = t_fin_rx;
          end
          FRM_REPORT: if (d.frame_seq == sess_seq) begin
            t_poll_rx = d.rep_poll_rx;
            t_ans_tx = d.rep_answer_tx;
            t_fin_rx = d.rep_final_rx;
            tf = flight_time();
            o.range_valid = tf[TOF_W];
            o.data.tof_ticks = tf[TOF_W-1:0];
          end
          default: ;
        endcase
        if (!o.send_now) begin
          o.data.send_seq = '0;
          o.data.send_source = '0;
          o.data.send_dest = '0;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_request(input logic [1:0] act, input in_data_t d);
    d.pad = '0;
    while (!tx_noidle && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_frames.push_back(predict(act, d));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] val);
    in_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NODE_ADDR: own_addr = val;
      REG_TX_DELAY: tx_add = val[15:0];
      default: rx_sub = val[15:0];
    endcase
  endtask

  always @(posedge clk) begin
    out_tready <= rx_noidle || ($urandom_range(99) >= 33);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_frames.size() == 0) report("result with nothing expected");
      else begin
        frame_out_t e;
        out_data_t g;
        e = expected_frames.pop_front();
        g = out_tdata;
        if (out_tuser[0] !== e.send_now) report("send_now");
        if (out_tuser[1] !== e.range_valid) report("range_valid");
        if (g.send_type !== e.data.send_type) report("send_type");
        if (g.send_seq !== e.data.send_seq) report("send_seq");
        if (g.send_source !== e.data.send_source) report("send_source");
        if (g.send_dest !== e.data.send_dest) report("send_dest");
        if (g.out_poll_rx !== e.data.out_poll_rx) report("out_poll_rx");
        if (g.out_answer_tx !== e.data.out_answer_tx) report("out_answer_tx");
        if (g.out_final_rx !== e.data.out_final_rx) report("out_final_rx");
        if (g.tof_ticks !== e.data.tof_ticks) report("tof_ticks");
      end
    end
  end

  function automatic in_data_t rand_frame();
    in_data_t d;
    d = TDATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom});
    d.frame_empty = ($urandom_range(19) == 0);
    return d;
  endfunction

  function automatic logic [TIME_W-1:0] near(input logic [TIME_W-1:0] base);
    case ($urandom_range(3))
      0: return base + TIME_W'($urandom_range(100000));
      1: return base + TIME_W'($urandom_range(3));
      2: return base + TIME_W'({$urandom, $urandom});
      default: return base - TIME_W'($urandom_range(1000));
    endcase
  endfunction

  // one ranging exchange seen from either side, with random timing content
  task automatic session(input bit faults);
    in_data_t d;
    logic [TIME_W-1:0] t;
    logic [ADDR_W-1:0] peer;
    logic [7:0] sq;
    t = TIME_W'({$urandom, $urandom});
    peer = {$urandom, $urandom};
    if ($urandom_range(1)) begin
      send_request(ACT_START, rand_frame());
      sq = sess_seq;
      d = rand_frame(); d.event_time = t; send_request(ACT_TX, d);
      d = rand_frame(); d.frame_empty = 1'b0; d.frame_type = FRM_ANSWER;
      d.frame_seq = (faults && $urandom_range(3) == 0) ? 8'($urandom) : sq;
      t = near(t); d.event_time = t; send_request(ACT_RX, d);
      d = rand_frame(); t = near(t); d.event_time = t; send_request(ACT_TX, d);
      d = rand_frame(); d.frame_empty = 1'b0; d.frame_type = FRM_REPORT;
      d.frame_seq = (faults && $urandom_range(3) == 0) ? 8'($urandom) : sq;
      if ($urandom_range(1)) begin
        d.rep_poll_rx = near(t); d.rep_answer_tx = near(d.rep_poll_rx);
        d.rep_final_rx = near(d.rep_answer_tx);
      end
      send_request(ACT_RX, d);
    end else begin
      d = rand_frame(); d.frame_empty = 1'b0; d.frame_type = FRM_POLL; d.frame_source = peer;
      d.event_time = t; send_request(ACT_RX, d);
      d = rand_frame(); t = near(t); d.event_time = t; send_request(ACT_TX, d);
      d = rand_frame(); d.frame_empty = 1'b0; d.frame_type = FRM_FINAL;
      d.frame_source = (faults && $urandom_range(3) == 0) ? {$urandom, $urandom} : peer;
      t = near(t); d.event_time = t; send_request(ACT_RX, d);
      d = rand_frame(); send_request(ACT_TX, d);
    end
  endtask

  task automatic test_directed();
    in_data_t d;
    send_request(ACT_TX, '0);
    send_request(ACT_START, '0);
    d = '0; d.event_time = '1; send_request(ACT_TX, d);
    d = '0; d.frame_type = FRM_POLL; d.frame_source = '1; d.frame_dest = '1;
    d.frame_seq = 8'hFF; send_request(ACT_RX, d);
    d = '0; send_request(ACT_TX, d);
    d = '0; d.frame_type = FRM_FINAL; d.frame_source = 64'hFF; send_request(ACT_RX, d);
    d.frame_source = '1; d.event_time = '1; send_request(ACT_RX, d);
    send_request(ACT_TX, d);
    d = '0; d.frame_type = FRM_ANSWER; d.frame_seq = 8'd2; send_request(ACT_RX, d);
    d.frame_seq = 8'd1; d.frame_empty = 1'b1; send_request(ACT_RX, d);
    d.frame_empty = 1'b0; send_request(ACT_RX, d);
    for (int k = 4; k < 8; k++) begin
      d.frame_type = k[2:0]; send_request(ACT_RX, d);
    end
    send_request(ACT_NONE, '1);
    d = '0; d.frame_type = FRM_REPORT; d.frame_seq = 8'd1; send_request(ACT_RX, d);
    send_request(ACT_START, '0);
    d.rep_poll_rx = '1; d.rep_answer_tx = '1; d.rep_final_rx = '1; send_request(ACT_RX, d);
    d.rep_poll_rx = 40'h00_0000_0000; d.rep_answer_tx = 40'hFF_FFFF_FFFF;
    d.rep_final_rx = 40'h00_8000_0000; send_request(ACT_RX, d);
    d.rep_poll_rx = 40'h00_FFFF_0000; d.rep_answer_tx = 40'h00_0000_0001;
    d.rep_final_rx = 40'h00_7FFF_0000; send_request(ACT_RX, d);
  endtask

  task automatic test_registers();
    write_reg(REG_NODE_ADDR, '1);
    write_reg(REG_TX_DELAY, 64'hFFFF);
    write_reg(REG_RX_DELAY, 64'hFFFF);
    repeat (40) session(1'b0);
    write_reg(REG_NODE_ADDR, '0);
    write_reg(REG_TX_DELAY, '0);
    write_reg(REG_RX_DELAY, '0);
    repeat (40) session(1'b0);
    write_reg(REG_NODE_ADDR, {$urandom, $urandom});
    write_reg(REG_TX_DELAY, ADDR_W'($urandom));
    write_reg(REG_RX_DELAY, ADDR_W'($urandom));
  endtask

  task automatic test_random();
    in_data_t d;
    rx_noidle = 1'b1; tx_noidle = 1'b1;
    repeat (30) session(1'b1);
    rx_noidle = 1'b0; tx_noidle = 1'b0;
    repeat (365) begin
      if ($urandom_range(4) == 0) begin
        d = rand_frame();
        send_request(2'($urandom_range(3)), d);
      end else session(1'b1);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    own_addr = NODE_ADDR_RST; tx_add = TX_DELAY_RST; rx_sub = RX_DELAY_RST;
    {t_poll_tx, t_poll_rx, t_ans_tx, t_ans_rx, t_fin_tx, t_fin_rx} = '0;
    sess_seq = '0; sess_peer = '0; last_type = ST_POLL;
    @(posedge clk);
    test_directed();
    test_registers();
    test_random();
    in_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
